// ----- src/ppc_pkg.sv -----
package ppc_pkg;

   localparam int MaxVerticesDefault = 16;
   localparam int DistW  = 52;
   localparam int AttrW  = 34;
   localparam int MulBW  = 18;
   localparam int ProdW  = AttrW + MulBW;
   localparam int TW     = 17;
   localparam int NumMix = 12;
   localparam int CsrIdxW = 3;

   localparam logic [CsrIdxW-1:0] CSR_NRM_X = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_NRM_Y = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_NRM_Z = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_PNT_X = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_PNT_Y = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_PNT_Z = 3'd5;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] nrm_x;
      logic signed [15:0] nrm_y;
      logic signed [15:0] nrm_z;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic [31:0]        rgba;
   } vertex_type;

   typedef enum logic [1:0] {OUT_VERTEX, OUT_CROSS, OUT_MARKER} out_kind_type;
   typedef enum logic {EDGE_PREV_CUR, EDGE_CUR_FIRST} edge_type;

   typedef struct packed {
      logic         capture;
      logic         dist_clear;
      logic         mul_dist;
      logic         mul_mix;
      logic         accum;
      logic         mix_write;
      logic [3:0]   idx;
      logic         commit_first;
      edge_type     edge_sel;
      logic         div_init;
      logic         div_step;
      logic         load_out;
      out_kind_type kind;
      logic         last;
      logic         advance;
   } dp_cmd_type;

   typedef struct packed {
      logic prev_neg;
      logic cur_neg;
      logic first_neg;
      logic out_busy;
   } dp_status_type;

   // Attribute as a sign-extended operand; colour channels are unsigned bytes
   function automatic logic signed [AttrW-1:0] attr_of(vertex_type v, logic [3:0] i);
      logic signed [AttrW-1:0] r;
      case (i)
         4'd0:    r = AttrW'(v.pos_x);
         4'd1:    r = AttrW'(v.pos_y);
         4'd2:    r = AttrW'(v.pos_z);
         4'd3:    r = AttrW'(v.nrm_x);
         4'd4:    r = AttrW'(v.nrm_y);
         4'd5:    r = AttrW'(v.nrm_z);
         4'd6:    r = AttrW'(v.tex_u);
         4'd7:    r = AttrW'(v.tex_v);
         4'd8:    r = AttrW'($signed({1'b0, v.rgba[7:0]}));
         4'd9:    r = AttrW'($signed({1'b0, v.rgba[15:8]}));
         4'd10:   r = AttrW'($signed({1'b0, v.rgba[23:16]}));
         4'd11:   r = AttrW'($signed({1'b0, v.rgba[31:24]}));
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- src/ppc_chan_if.sv -----
interface ppc_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [15:0] nrm_x;
   logic signed [15:0] nrm_y;
   logic signed [15:0] nrm_z;
   logic signed [31:0] tex_u;
   logic signed [31:0] tex_v;
   logic [31:0]        rgba;
   logic               last_vertex;
   modport source (output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v,
                   rgba, last_vertex, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v,
                 rgba, last_vertex, output ready);
endinterface

interface ppc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_pos_x;
   logic signed [31:0] out_pos_y;
   logic signed [31:0] out_pos_z;
   logic signed [15:0] out_nrm_x;
   logic signed [15:0] out_nrm_y;
   logic signed [15:0] out_nrm_z;
   logic signed [31:0] out_tex_u;
   logic signed [31:0] out_tex_v;
   logic [31:0]        out_rgba;
   logic               vertex_valid;
   logic               last_out;
   modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                   out_nrm_z, out_tex_u, out_tex_v, out_rgba, vertex_valid, last_out,
                   input ready);
   modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                 out_nrm_z, out_tex_u, out_tex_v, out_rgba, vertex_valid, last_out,
                 output ready);
endinterface

interface ppc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- src/ppc_datapath.sv -----
module ppc_datapath
   import ppc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ppc_req_if.sink       req_chan,
   ppc_rsp_if.source     rsp_chan,
   ppc_csr_if.sink       csr_chan,
   input  dp_cmd_type    cmd,
   output dp_status_type status
);

   logic signed [15:0] nrm_ff [3];
   logic signed [31:0] pnt_ff [3];

   vertex_type cur_ff, prev_ff, first_ff;
   logic signed [DistW-1:0] dist_ff, dprev_ff, dfirst_ff;
   logic signed [ProdW-1:0] prod_ff;

   logic [DistW+1:0] rem_ff;
   logic [DistW:0]   den_ff;
   logic [15:0]      quo_ff;
   logic             full_ff;

   logic [31:0] res_ff [NumMix];

   vertex_type out_ff;
   logic       out_vv_ff, out_last_ff, out_valid_ff;

   vertex_type a_v, b_v;
   logic signed [DistW-1:0] da, db;
   logic [DistW-1:0] abs_a, abs_b;
   logic [DistW:0]   den_in;
   logic [DistW+1:0] rem_sh;
   logic [TW-1:0]    t_val;
   logic signed [AttrW-1:0] op_a;
   logic signed [MulBW-1:0] op_b;
   logic signed [AttrW-1:0] pq_diff, mix_diff;
   logic [1:0]  didx;
   logic signed [ProdW-1:0] mix_sum;
   vertex_type cross_v;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            nrm_ff[i] <= '0;
            pnt_ff[i] <= '0;
         end
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_NRM_X: nrm_ff[0] <= csr_chan.data[15:0];
            CSR_NRM_Y: nrm_ff[1] <= csr_chan.data[15:0];
            CSR_NRM_Z: nrm_ff[2] <= csr_chan.data[15:0];
            CSR_PNT_X: pnt_ff[0] <= csr_chan.data;
            CSR_PNT_Y: pnt_ff[1] <= csr_chan.data;
            CSR_PNT_Z: pnt_ff[2] <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Edge endpoints
   always_comb begin
      if (cmd.edge_sel == EDGE_PREV_CUR) begin
         a_v = prev_ff; b_v = cur_ff; da = dprev_ff; db = dist_ff;
      end else begin
         a_v = cur_ff; b_v = first_ff; da = dist_ff; db = dfirst_ff;
      end
   end

   assign abs_a  = da[DistW-1] ? DistW'(-da) : DistW'(da);
   assign abs_b  = db[DistW-1] ? DistW'(-db) : DistW'(db);
   assign den_in = {1'b0, abs_a} + {1'b0, abs_b};
   assign rem_sh = {rem_ff[DistW:0], 1'b0};
   assign t_val  = full_ff ? TW'(17'h10000) : {1'b0, quo_ff};

   assign didx = cmd.idx[1:0];
   always_comb begin
      case (didx)
         2'd0:    pq_diff = AttrW'(cur_ff.pos_x) - AttrW'(pnt_ff[0]);
         2'd1:    pq_diff = AttrW'(cur_ff.pos_y) - AttrW'(pnt_ff[1]);
         default: pq_diff = AttrW'(cur_ff.pos_z) - AttrW'(pnt_ff[2]);
      endcase
   end
   assign mix_diff = attr_of(b_v, cmd.idx) - attr_of(a_v, cmd.idx);
   assign op_a = cmd.mul_dist ? pq_diff : mix_diff;
   assign op_b = cmd.mul_dist ? MulBW'(nrm_ff[(didx == 2'd3) ? 2'd2 : didx])
                              : $signed({1'b0, t_val});
   // Floor of the scaled difference is an arithmetic shift
   assign mix_sum = ProdW'(attr_of(a_v, cmd.idx)) + (prod_ff >>> 16);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff.pos_x <= req_chan.pos_x;
         cur_ff.pos_y <= req_chan.pos_y;
         cur_ff.pos_z <= req_chan.pos_z;
         cur_ff.nrm_x <= req_chan.nrm_x;
         cur_ff.nrm_y <= req_chan.nrm_y;
         cur_ff.nrm_z <= req_chan.nrm_z;
         cur_ff.tex_u <= req_chan.tex_u;
         cur_ff.tex_v <= req_chan.tex_v;
         cur_ff.rgba  <= req_chan.rgba;
      end
      if (cmd.mul_dist || cmd.mul_dist == 1'b0 && cmd.mul_mix)
         prod_ff <= op_a * op_b;
      if (cmd.mix_write)
         res_ff[cmd.idx] <= mix_sum[31:0];
      if (cmd.commit_first)
         first_ff <= cur_ff;
      if (cmd.advance)
         prev_ff <= cur_ff;
      if (cmd.div_init) begin
         rem_ff  <= {2'b00, abs_a};
         den_ff  <= den_in;
         quo_ff  <= '0;
         full_ff <= ({1'b0, abs_a} >= den_in);
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= rem_sh - {1'b0, den_ff};
            quo_ff <= {quo_ff[14:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            quo_ff <= {quo_ff[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff   <= '0;
         dprev_ff  <= '0;
         dfirst_ff <= '0;
      end else begin
         if (cmd.dist_clear)
            dist_ff <= '0;
         else if (cmd.accum)
            dist_ff <= dist_ff + DistW'(prod_ff);
         if (cmd.commit_first)
            dfirst_ff <= dist_ff;
         if (cmd.advance)
            dprev_ff <= dist_ff;
      end
   end

   always_comb begin
      cross_v.pos_x = res_ff[0];
      cross_v.pos_y = res_ff[1];
      cross_v.pos_z = res_ff[2];
      cross_v.nrm_x = res_ff[3][15:0];
      cross_v.nrm_y = res_ff[4][15:0];
      cross_v.nrm_z = res_ff[5][15:0];
      cross_v.tex_u = res_ff[6];
      cross_v.tex_v = res_ff[7];
      cross_v.rgba  = {res_ff[11][7:0], res_ff[10][7:0], res_ff[9][7:0], res_ff[8][7:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.load_out) begin
         out_last_ff <= cmd.last;
         case (cmd.kind)
            OUT_VERTEX: begin out_ff <= b_v; out_vv_ff <= 1'b1; end
            OUT_CROSS:  begin out_ff <= cross_v; out_vv_ff <= 1'b1; end
            default:    begin out_ff <= '0; out_vv_ff <= 1'b0; end
         endcase
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.out_pos_x    = out_ff.pos_x;
   assign rsp_chan.out_pos_y    = out_ff.pos_y;
   assign rsp_chan.out_pos_z    = out_ff.pos_z;
   assign rsp_chan.out_nrm_x    = out_ff.nrm_x;
   assign rsp_chan.out_nrm_y    = out_ff.nrm_y;
   assign rsp_chan.out_nrm_z    = out_ff.nrm_z;
   assign rsp_chan.out_tex_u    = out_ff.tex_u;
   assign rsp_chan.out_tex_v    = out_ff.tex_v;
   assign rsp_chan.out_rgba     = out_ff.rgba;
   assign rsp_chan.vertex_valid = out_vv_ff;
   assign rsp_chan.last_out     = out_last_ff;

   assign status.prev_neg  = dprev_ff[DistW-1];
   assign status.cur_neg   = dist_ff[DistW-1];
   assign status.first_neg = dfirst_ff[DistW-1];
   assign status.out_busy  = out_valid_ff;

endmodule

// ----- src/ppc_control.sv -----
module ppc_control
   import ppc_pkg::*;
#(
   parameter int MAX_VERTICES = MaxVerticesDefault
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_last,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int CntW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DIST, S_PLAN, S_SCAN, S_DIV, S_MIX, S_EMIT, S_DONE
   } state_type;

   state_type    state_ff;
   logic [4:0]   cnt_ff;
   logic [1:0]   slot_ff;
   logic [3:0]   mask_ff;
   logic [2:0]   left_ff;
   logic         last_ff, have_first_ff;
   logic [CntW-1:0] count_ff;
   out_kind_type kind_ff;

   logic         first_neg_eff;
   logic [3:0]   en;
   logic [2:0]   total;
   logic [CntW-1:0] base;
   logic [CntW:0]   room;
   logic [2:0]   take;

   assign req_ready = (state_ff == S_IDLE);

   // Output slots in order: entering crossing, current vertex, closing crossing, first vertex
   always_comb begin
      first_neg_eff = have_first_ff ? status.first_neg : status.cur_neg;
      en[0] = have_first_ff && (status.prev_neg != status.cur_neg);
      en[1] = have_first_ff && !status.cur_neg;
      en[2] = last_ff && (status.cur_neg != first_neg_eff);
      en[3] = last_ff && !first_neg_eff;
      total = 3'(en[0]) + 3'(en[1]) + 3'(en[2]) + 3'(en[3]);
      base  = have_first_ff ? count_ff : '0;
      room  = (CntW+1)'(MAX_VERTICES) - {1'b0, base};
      take  = (room < (CntW+1)'(total)) ? room[2:0] : total;
   end

   always_comb begin
      cmd = '0;
      cmd.edge_sel = slot_ff[1] ? EDGE_CUR_FIRST : EDGE_PREV_CUR;
      cmd.kind = kind_ff;
      cmd.idx = cnt_ff[4:1];
      case (state_ff)
         S_IDLE: begin
            cmd.capture    = req_valid;
            cmd.dist_clear = req_valid;
         end
         S_DIST: begin
            cmd.mul_dist = !cnt_ff[0];
            cmd.accum    = cnt_ff[0];
         end
         S_PLAN: cmd.commit_first = !have_first_ff;
         S_SCAN: cmd.div_init = (left_ff != '0) && mask_ff[slot_ff] && !slot_ff[0];
         S_DIV:  cmd.div_step = 1'b1;
         S_MIX: begin
            cmd.mul_mix   = !cnt_ff[0];
            cmd.mix_write = cnt_ff[0];
         end
         S_EMIT: begin
            cmd.load_out = !status.out_busy;
            cmd.last     = (kind_ff == OUT_MARKER) || (last_ff && left_ff == 3'd1);
         end
         S_DONE: cmd.advance = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         slot_ff       <= '0;
         mask_ff       <= '0;
         left_ff       <= '0;
         last_ff       <= 1'b0;
         have_first_ff <= 1'b0;
         count_ff      <= '0;
         kind_ff       <= OUT_VERTEX;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) begin
               last_ff  <= req_last;
               cnt_ff   <= '0;
               state_ff <= S_DIST;
            end
            S_DIST: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd5) state_ff <= S_PLAN;
            end
            S_PLAN: begin
               mask_ff       <= en;
               slot_ff       <= '0;
               left_ff       <= take;
               have_first_ff <= !last_ff;
               count_ff      <= last_ff ? '0 : base + CntW'(take);
               if (last_ff && take == '0) begin
                  kind_ff  <= OUT_MARKER;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (left_ff == '0) begin
                  state_ff <= S_DONE;
               end else if (!mask_ff[slot_ff]) begin
                  slot_ff <= slot_ff + 2'd1;
               end else if (!slot_ff[0]) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end else begin
                  kind_ff  <= OUT_VERTEX;
                  state_ff <= S_EMIT;
               end
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd15) begin
                  cnt_ff   <= '0;
                  state_ff <= S_MIX;
               end
            end
            S_MIX: begin
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(2 * NumMix - 1)) begin
                  kind_ff  <= OUT_CROSS;
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: if (!status.out_busy) begin
               if (kind_ff == OUT_MARKER) begin
                  state_ff <= S_DONE;
               end else begin
                  left_ff          <= left_ff - 3'd1;
                  mask_ff[slot_ff] <= 1'b0;
                  slot_ff          <= slot_ff + 2'd1;
                  state_ff         <= S_SCAN;
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- src/polygon_plane_clipper_unit.sv -----
// Clips a polygon against one plane, one vertex transfer at a time.
// req_chan: vertex in (valid/ready), last_vertex closes the polygon.
// rsp_chan: clipped vertices out (valid/ready); last_out marks the final
//   result of the polygon, and an end marker with vertex_valid low is sent
//   when the closing vertex yields nothing.
// csr_chan: plane normal (index 0..2) and plane point (index 3..5); write
//   only while no polygon is in flight. Always ready.
// Sequence: one vertex at a time. The plane distance is formed on the
//   shared 34x18 multiplier and the results are planned; then each kept
//   vertex is selected and loaded into the output, and each crossing is
//   selected, its t found by the restoring divider, its attributes
//   interpolated on the same multiplier and the result loaded into the
//   output. Slots with no result are skipped, and the vertex then finishes.
// Results leave through a single output register; when the receiver stalls
//   the next result waits in the datapath and no new vertex is taken.
// Reset (synchronous) clears the plane registers, the polygon state and the
//   output valid flag; the block is ready the cycle after.
module polygon_plane_clipper_unit
   import ppc_pkg::*;
#(
   parameter int MAX_VERTICES = MaxVerticesDefault
)(
   input  logic      clock,
   input  logic      reset,
   ppc_req_if.sink   req_chan,
   ppc_rsp_if.source rsp_chan,
   ppc_csr_if.sink   csr_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          ready;

   assign req_chan.ready = ready;

   ppc_control #(.MAX_VERTICES(MAX_VERTICES)) u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .req_last  (req_chan.last_vertex),
      .status    (status),
      .cmd       (cmd)
   );

   ppc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import ppc_pkg::*;

   localparam int CapVertices = MaxVerticesDefault;
   localparam int CycleLimit  = 2000000;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] nrm_x;
      logic signed [15:0] nrm_y;
      logic signed [15:0] nrm_z;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic [31:0]        rgba;
      logic               vertex_valid;
      logic               last_out;
   } clip_vertex_type;

   typedef struct packed {
      vertex_type v;
      logic       last;
   } req_item_type;

   // directed row: vertex plus the result count typed in where obvious (-1 = predict only)
   typedef struct {
      req_item_type item;
      int           fixed_count;
      logic         want_marker;
   } vertex_row_type;

   logic clock;
   logic reset;
   ppc_req_if req_chan ();
   ppc_rsp_if rsp_chan ();
   ppc_csr_if csr_chan ();

   polygon_plane_clipper_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // predictor state
   logic signed [15:0] plane_nrm [3];
   logic signed [31:0] plane_pnt [3];
   vertex_type         first_v;
   vertex_type         prev_v;
   longint             first_dist;
   longint             prev_dist;
   int                 emitted;
   bit                 polygon_open;

   clip_vertex_type clipped_queue [$];
   int  failures;
   int  cycle_count;
   int  send_idle_pct;
   int  recv_stall_pct;

   function automatic longint plane_dist(vertex_type v);
      longint dot_p;
      longint dot_q;
      dot_p = longint'(plane_nrm[0]) * longint'(v.pos_x) + longint'(plane_nrm[1]) * longint'(v.pos_y)
            + longint'(plane_nrm[2]) * longint'(v.pos_z);
      dot_q = longint'(plane_nrm[0]) * longint'(plane_pnt[0])
            + longint'(plane_nrm[1]) * longint'(plane_pnt[1])
            + longint'(plane_nrm[2]) * longint'(plane_pnt[2]);
      return dot_p - dot_q;
   endfunction

   function automatic longint lerp_attr(longint a, longint b, longint t);
      longint p;
      longint q;
      p = (b - a) * t;
      q = p >>> 16;  // arithmetic shift floors
      return a + q;
   endfunction

   function automatic longint crossing_frac(longint da, longint db);
      longint unsigned num;
      longint unsigned den;
      longint unsigned rem;
      longint unsigned q;
      num = da < 0 ? -da : da;
      den = num + (db < 0 ? -db : db);
      if (num >= den) return 65536;
      rem = num;
      q = 0;
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 1;
         end
      end
      return longint'(q);
   endfunction

   function automatic void emit_vertex(vertex_type v);
      clip_vertex_type r;
      if (emitted >= CapVertices) return;
      r.pos_x = v.pos_x;
      r.pos_y = v.pos_y;
      r.pos_z = v.pos_z;
      r.nrm_x = v.nrm_x;
      r.nrm_y = v.nrm_y;
      r.nrm_z = v.nrm_z;
      r.tex_u = v.tex_u;
      r.tex_v = v.tex_v;
      r.rgba  = v.rgba;
      r.vertex_valid = 1'b1;
      r.last_out = 1'b0;
      clipped_queue.push_back(r);
      emitted++;
   endfunction

   function automatic void emit_crossing(vertex_type a, longint da, vertex_type b, longint db);
      vertex_type r;
      longint t;
      t = crossing_frac(da, db);
      r.pos_x = 32'(lerp_attr(a.pos_x, b.pos_x, t));
      r.pos_y = 32'(lerp_attr(a.pos_y, b.pos_y, t));
      r.pos_z = 32'(lerp_attr(a.pos_z, b.pos_z, t));
      r.nrm_x = 16'(lerp_attr(a.nrm_x, b.nrm_x, t));
      r.nrm_y = 16'(lerp_attr(a.nrm_y, b.nrm_y, t));
      r.nrm_z = 16'(lerp_attr(a.nrm_z, b.nrm_z, t));
      r.tex_u = 32'(lerp_attr(a.tex_u, b.tex_u, t));
      r.tex_v = 32'(lerp_attr(a.tex_v, b.tex_v, t));
      for (int sh = 0; sh < 32; sh += 8)
         r.rgba[sh +: 8] = 8'(lerp_attr(longint'(a.rgba[sh +: 8]), longint'(b.rgba[sh +: 8]),
                                        t));
      emit_vertex(r);
   endfunction

   function automatic void clip_edge(vertex_type a, longint da, vertex_type b, longint db);
      if (db >= 0) begin
         if (da < 0) emit_crossing(a, da, b, db);
         emit_vertex(b);
      end else if (da >= 0) begin
         emit_crossing(a, da, b, db);
      end
   endfunction

   // returns the number of results this vertex causes
   function automatic int clip_accept(req_item_type it);
      longint d;
      int before_n;
      clip_vertex_type marker;
      before_n = clipped_queue.size();
      d = plane_dist(it.v);
      if (!polygon_open) begin
         first_v = it.v;
         first_dist = d;
         emitted = 0;
         polygon_open = 1'b1;
      end else begin
         clip_edge(prev_v, prev_dist, it.v, d);
      end
      prev_v = it.v;
      prev_dist = d;
      if (it.last) begin
         clip_edge(prev_v, prev_dist, first_v, first_dist);
         if (clipped_queue.size() == before_n) begin
            marker = '0;
            marker.last_out = 1'b1;
            clipped_queue.push_back(marker);
         end else begin
            clipped_queue[$].last_out = 1'b1;
         end
         polygon_open = 1'b0;
         emitted = 0;
      end
      return clipped_queue.size() - before_n;
   endfunction

   task automatic wait_drained();
      while (clipped_queue.size() != 0) @(posedge clock);
      // an accepted vertex may still be in flight with nothing expected
      repeat (150) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CsrIdxW-1:0] idx, logic [31:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (idx)
         CSR_NRM_X: plane_nrm[0] = value[15:0];
         CSR_NRM_Y: plane_nrm[1] = value[15:0];
         CSR_NRM_Z: plane_nrm[2] = value[15:0];
         CSR_PNT_X: plane_pnt[0] = value;
         CSR_PNT_Y: plane_pnt[1] = value;
         CSR_PNT_Z: plane_pnt[2] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                            logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
      csr_write(CSR_NRM_X, {16'h0, nx});
      csr_write(CSR_NRM_Y, {16'h0, ny});
      csr_write(CSR_NRM_Z, {16'h0, nz});
      csr_write(CSR_PNT_X, qx);
      csr_write(CSR_PNT_Y, qy);
      csr_write(CSR_PNT_Z, qz);
   endtask

   // called at a falling edge, returns at a falling edge after the transfer
   task automatic send_vertex(req_item_type it, output int n_results);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.pos_x <= it.v.pos_x;
      req_chan.pos_y <= it.v.pos_y;
      req_chan.pos_z <= it.v.pos_z;
      req_chan.nrm_x <= it.v.nrm_x;
      req_chan.nrm_y <= it.v.nrm_y;
      req_chan.nrm_z <= it.v.nrm_z;
      req_chan.tex_u <= it.v.tex_u;
      req_chan.tex_v <= it.v.tex_v;
      req_chan.rgba  <= it.v.rgba;
      req_chan.last_vertex <= it.last;
      do @(posedge clock); while (!req_chan.ready);
      n_results = clip_accept(it);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(131072) - 65536;
         default: return $urandom;
      endcase
   endfunction

   function automatic vertex_type rand_vertex(bit wide);
      vertex_type v;
      if (wide) begin
         v.pos_x = rand_word();
         v.pos_y = rand_word();
         v.pos_z = rand_word();
      end else begin
         // near the plane so that crossings are common
         v.pos_x = $urandom_range(32'h0010_0000) - 32'h0008_0000;
         v.pos_y = $urandom_range(32'h0010_0000) - 32'h0008_0000;
         v.pos_z = $urandom_range(32'h0010_0000) - 32'h0008_0000;
      end
      v.nrm_x = 16'($urandom);
      v.nrm_y = 16'($urandom);
      v.nrm_z = 16'($urandom);
      v.tex_u = rand_word();
      v.tex_v = rand_word();
      v.rgba  = $urandom;
      return v;
   endfunction

   // receiver: stall at random, check each transfer against the oldest expectation
   always @(negedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      clip_vertex_type got;
      clip_vertex_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.out_pos_x, rsp_chan.out_pos_y, rsp_chan.out_pos_z,
                rsp_chan.out_nrm_x, rsp_chan.out_nrm_y, rsp_chan.out_nrm_z,
                rsp_chan.out_tex_u, rsp_chan.out_tex_v, rsp_chan.out_rgba,
                rsp_chan.vertex_valid, rsp_chan.last_out};
         if (clipped_queue.size() == 0) begin
            $display("%0t: unexpected transfer %h", $realtime, got);
            failures++;
         end else begin
            want = clipped_queue.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   initial begin
      vertex_row_type rows [$];
      vertex_row_type row;
      req_item_type   it;
      vertex_type     zv;
      int             n;
      int             poly_len;
      int             pcnt;
      bit             paused;

      failures = 0;
      cycle_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      plane_nrm = '{default: '0};
      plane_pnt = '{default: '0};
      polygon_open = 1'b0;
      emitted = 0;
      first_dist = 0;
      prev_dist = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.pos_z = '0;
      req_chan.nrm_x = '0;
      req_chan.nrm_y = '0;
      req_chan.nrm_z = '0;
      req_chan.tex_u = '0;
      req_chan.tex_v = '0;
      req_chan.rgba  = '0;
      req_chan.last_vertex = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_NRM_X;
      csr_chan.data  = '0;
      rsp_chan.ready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // after reset the plane is zero: every distance is zero, all vertices inside
      zv = '0;
      row.item = '{v: zv, last: 1'b1};
      row.fixed_count = 1;
      row.want_marker = 1'b0;
      rows.push_back(row);
      zv.pos_x = 32'h7FFF_FFFF; zv.pos_y = 32'h8000_0000; zv.pos_z = 32'h7FFF_FFFF;
      zv.nrm_x = 16'h7FFF; zv.nrm_y = 16'h8000; zv.nrm_z = 16'hFFFF;
      zv.tex_u = 32'h8000_0000; zv.tex_v = 32'h7FFF_FFFF; zv.rgba = 32'hFFFF_FFFF;
      row.item = '{v: zv, last: 1'b0};
      row.fixed_count = 0;
      rows.push_back(row);
      row.item = '{v: ~zv, last: 1'b1};
      row.fixed_count = 2;
      rows.push_back(row);
      foreach (rows[i]) begin
         send_vertex(rows[i].item, n);
         if (rows[i].fixed_count >= 0 && n != rows[i].fixed_count) begin
            $display("%0t: count mismatch expected %0d actual %0d", $realtime,
                     rows[i].fixed_count, n);
            failures++;
         end
      end
      wait_drained();

      // plane x >= 0 at extreme normal: crossings, enter/leave, exact zero, empty end
      set_plane(16'h7FFF, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
      rows.delete();
      row.fixed_count = -1;
      row.want_marker = 1'b0;
      // fully outside single vertex: end marker with vertex_valid clear
      zv = '0; zv.pos_x = 32'hFFFF_0000; zv.rgba = 32'h1234_5678;
      row.item = '{v: zv, last: 1'b1}; row.fixed_count = 1; row.want_marker = 1'b1;
      rows.push_back(row);
      row.fixed_count = -1; row.want_marker = 1'b0;
      // triangle crossing the plane, one vertex exactly on it
      zv = '0; zv.pos_x = 32'hFFFE_0000; zv.rgba = 32'h00FF_10F0; zv.tex_u = 32'h8000_0000;
      row.item = '{v: zv, last: 1'b0}; rows.push_back(row);
      zv = '0; zv.pos_x = 32'h0003_0000; zv.pos_y = 32'h0001_0000; zv.rgba = 32'hFF00_F010;
      zv.tex_u = 32'h7FFF_FFFF; zv.nrm_z = 16'h8000;
      row.item = '{v: zv, last: 1'b0}; rows.push_back(row);
      zv = '0; zv.pos_y = 32'h0005_0000; zv.nrm_x = 16'h7FFF;
      row.item = '{v: zv, last: 1'b1}; rows.push_back(row);
      // polygon longer than the vertex cap, alternating sides
      for (int k = 0; k < 20; k++) begin
         zv = rand_vertex(1'b0);
         zv.pos_x = (k % 2) ? 32'h0002_0000 : 32'hFFFE_0000;
         row.item = '{v: zv, last: k == 19};
         rows.push_back(row);
      end
      foreach (rows[i]) begin
         send_vertex(rows[i].item, n);
         if (rows[i].fixed_count >= 0 && n != rows[i].fixed_count) begin
            $display("%0t: count mismatch expected %0d actual %0d", $realtime,
                     rows[i].fixed_count, n);
            failures++;
         end
         if (rows[i].want_marker && clipped_queue.size() != 0
             && clipped_queue[$].vertex_valid !== 1'b0) begin
            $display("%0t: end marker expected 0 actual 1", $realtime);
            failures++;
         end
      end
      wait_drained();

      // random polygons under several planes and idling phases
      pcnt = 0;
      paused = 1'b0;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            3: begin send_idle_pct = 22; recv_stall_pct = 22; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         case (phase)
            0: set_plane(16'h4000, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0);
            1: set_plane(16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF);
            2: set_plane(16'($urandom), 16'($urandom), 16'($urandom),
                         $urandom_range(32'h40000), $urandom_range(32'h40000),
                         $urandom_range(32'h40000));
            3: set_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000);
            default: set_plane(16'h0, 16'h2000, 16'hE000, 32'h0001_0000, 32'h0, 32'hFFFF_0000);
         endcase
         n = 0;
         while (n < 66) begin
            poly_len = ($urandom_range(9) == 0) ? $urandom_range(24, 17) : $urandom_range(6, 1);
            for (int k = 0; k < poly_len; k++) begin
               it.v = rand_vertex($urandom_range(4) == 0);
               it.last = (k == poly_len - 1);
               send_vertex(it, pcnt);
               n++;
            end
            if (phase == 4 && n > 30 && !paused) begin
               // hold off until everything outstanding has come back
               paused = 1'b1;
               while (clipped_queue.size() != 0) @(negedge clock);
            end
         end
         wait_drained();
      end

      if (failures == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// ----- sim.f -----
src/ppc_pkg.sv
src/ppc_chan_if.sv
src/ppc_datapath.sv
src/ppc_control.sv
src/polygon_plane_clipper_unit.sv
test/testbench.sv
